[rtl/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared result types and output limits for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

   // Width of one root part on the result channel
   localparam int ROOT_W = 17;

   typedef logic signed [ROOT_W-1:0] root_type;

   // Saturation limits of a root part
   localparam logic signed [ROOT_W-1:0] ROOT_MAX = 17'sd65535;
   localparam logic signed [ROOT_W-1:0] ROOT_MIN = -17'sd65536;

endpackage

[rtl/quadratic_root_solver_top.sv]
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Pipeline: products, discriminant, square root, numerators, divider prep, dividers,
//   output register; EW = min(COEF_WIDTH,31).
// Throughput: one item per cycle; the whole pipe holds when the result is stalled.
// Depth set by the square root (EW+1 stages) and the two dividers (EW+2 stages).
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top #(
   parameter int COEF_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [COEF_WIDTH-1:0]   req_coef_a,
   input  logic [COEF_WIDTH-1:0]   req_coef_b,
   input  logic [COEF_WIDTH-1:0]   req_coef_c,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output qrs_pkg::root_type       rsp_root1_real,
   output qrs_pkg::root_type       rsp_root1_imag,
   output qrs_pkg::root_type       rsp_root2_real,
   output qrs_pkg::root_type       rsp_root2_imag,
   output logic                    rsp_not_quadratic
);

   localparam int EW = (COEF_WIDTH > 31) ? 31 : COEF_WIDTH; // used coef width
   localparam int PW = 2*EW;        // product width
   localparam int DW = 2*EW+2;      // discriminant width
   localparam int RW = EW+1;        // square root bits
   localparam int SW = RW+3;        // square root remainder
   localparam int NW = EW+3;        // signed numerator
   localparam int MW = EW+2;        // numerator magnitude / quotient bits
   localparam int VW = EW+1;        // divisor width
   localparam int QW = VW+1;        // divider remainder
   localparam int XW = MW+18;       // saturation compare width

   logic adv;

   // Whole pipe moves unless a result sits unread
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage M: products ----------------
   logic                 m_v_ff;
   logic signed [EW-1:0] m_a_ff, m_b_ff;
   logic signed [PW-1:0] m_bb_ff, m_ac_ff;
   logic signed [EW-1:0] a_in, b_in, c_in;

   assign a_in = req_coef_a[EW-1:0];
   assign b_in = req_coef_b[EW-1:0];
   assign c_in = req_coef_c[EW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (adv) begin
         m_v_ff <= req_valid;
      end
      if (adv) begin
         m_a_ff  <= a_in;
         m_b_ff  <= b_in;
         m_bb_ff <= b_in * b_in;
         m_ac_ff <= a_in * c_in;
      end
   end

   // ---------------- square root stages ----------------
   logic [RW:0]                 sq_v_ff;
   logic [SW-1:0]               sq_rem_ff  [0:RW];
   logic [RW-1:0]               sq_root_ff [0:RW];
   logic [DW-1:0]               sq_n_ff    [0:RW];
   logic signed [EW-1:0]        sq_a_ff    [0:RW];
   logic signed [EW-1:0]        sq_b_ff    [0:RW];
   logic [RW:0]                 sq_neg_ff;

   // Stage 0: discriminant magnitude and sign
   logic signed [DW-1:0] d_pos, d_neg;
   assign d_pos = DW'(m_bb_ff) - (DW'(m_ac_ff) <<< 2);
   assign d_neg = (DW'(m_ac_ff) <<< 2) - DW'(m_bb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= m_v_ff;
      end
      if (adv) begin
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_n_ff[0]    <= d_pos[DW-1] ? d_neg : d_pos;
         sq_neg_ff[0]  <= d_pos[DW-1];
         sq_a_ff[0]    <= m_a_ff;
         sq_b_ff[0]    <= m_b_ff;
      end
   end

   // One root bit per stage, restoring
   for (genvar k = 1; k <= RW; k++) begin : g_sq
      logic [SW-1:0] rem_t, trial;
      assign rem_t = {sq_rem_ff[k-1][SW-3:0], sq_n_ff[k-1][DW-1:DW-2]};
      assign trial = SW'({sq_root_ff[k-1], 2'b01});

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k] <= sq_v_ff[k-1];
         end
         if (adv) begin
            if (rem_t >= trial) begin
               sq_rem_ff[k]  <= rem_t - trial;
               sq_root_ff[k] <= {sq_root_ff[k-1][RW-2:0], 1'b1};
            end else begin
               sq_rem_ff[k]  <= rem_t;
               sq_root_ff[k] <= {sq_root_ff[k-1][RW-2:0], 1'b0};
            end
            sq_n_ff[k]   <= {sq_n_ff[k-1][DW-3:0], 2'b00};
            sq_neg_ff[k] <= sq_neg_ff[k-1];
            sq_a_ff[k]   <= sq_a_ff[k-1];
            sq_b_ff[k]   <= sq_b_ff[k-1];
         end
      end
   end

   // ---------------- prep 1: numerators of both roots ----------------
   logic                 p1_v_ff, p1_neg_ff, p1_aneg_ff, p1_nq_ff;
   logic signed [NW-1:0] p1_p_ff, p1_r_ff, p1_np_ff, p1_nm_ff;
   logic [VW-1:0]        p1_den_ff;

   logic                 s_aneg, s_exact;
   logic signed [NW-1:0] s_p, s_r, s_np, s_nm;
   logic signed [VW-1:0] s_a2;

   always_comb begin
      s_aneg  = sq_a_ff[RW][EW-1];
      s_exact = (sq_rem_ff[RW] == '0);
      s_p     = s_aneg ? NW'(sq_b_ff[RW]) : -NW'(sq_b_ff[RW]);
      s_r     = NW'({1'b0, sq_root_ff[RW]});
      s_np    = s_p + s_r;
      s_nm    = s_p - s_r;
      s_a2    = VW'(sq_a_ff[RW]) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (adv) begin
         p1_v_ff <= sq_v_ff[RW];
      end
      if (adv) begin
         // inexact roots: root is floored; raise a negative p+r by one, lower a positive p-r by one
         p1_np_ff   <= (!s_exact && s_np[NW-1]) ? s_np + NW'(1) : s_np;
         p1_nm_ff   <= (!s_exact && !s_nm[NW-1] && s_nm != '0) ? s_nm - NW'(1) : s_nm;
         p1_p_ff    <= s_p;
         p1_r_ff    <= s_r;
         p1_neg_ff  <= sq_neg_ff[RW];
         p1_aneg_ff <= s_aneg;
         p1_nq_ff   <= (sq_a_ff[RW] == '0);
         p1_den_ff  <= s_aneg ? -s_a2 : s_a2;
      end
   end

   // ---------------- prep 2 and divider stages ----------------
   logic [MW:0]     dv_v_ff;
   logic [QW-1:0]   dv_xr_ff [0:MW];
   logic [QW-1:0]   dv_yr_ff [0:MW];
   logic [MW-1:0]   dv_xq_ff [0:MW];
   logic [MW-1:0]   dv_yq_ff [0:MW];
   logic [VW-1:0]   dv_den_ff [0:MW];
   logic [MW:0]     dv_xs_ff, dv_ys_ff, dv_neg_ff, dv_aneg_ff, dv_nq_ff;

   logic signed [NW-1:0] s_x, s_y;
   always_comb begin
      if (p1_neg_ff) begin
         s_x = p1_p_ff;
         s_y = p1_r_ff;
      end else begin
         s_x = p1_aneg_ff ? p1_nm_ff : p1_np_ff;
         s_y = p1_aneg_ff ? p1_np_ff : p1_nm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= p1_v_ff;
      end
      if (adv) begin
         dv_xr_ff[0]   <= '0;
         dv_yr_ff[0]   <= '0;
         dv_xq_ff[0]   <= s_x[NW-1] ? MW'(-s_x) : MW'(s_x);
         dv_yq_ff[0]   <= s_y[NW-1] ? MW'(-s_y) : MW'(s_y);
         dv_xs_ff[0]   <= s_x[NW-1];
         dv_ys_ff[0]   <= s_y[NW-1];
         dv_den_ff[0]  <= p1_den_ff;
         dv_neg_ff[0]  <= p1_neg_ff;
         dv_aneg_ff[0] <= p1_aneg_ff;
         dv_nq_ff[0]   <= p1_nq_ff;
      end
   end

   // One quotient bit per stage for both dividers
   for (genvar j = 1; j <= MW; j++) begin : g_dv
      logic [QW-1:0] xt, yt, dn;
      assign xt = {dv_xr_ff[j-1][QW-2:0], dv_xq_ff[j-1][MW-1]};
      assign yt = {dv_yr_ff[j-1][QW-2:0], dv_yq_ff[j-1][MW-1]};
      assign dn = QW'(dv_den_ff[j-1]);

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j] <= dv_v_ff[j-1];
         end
         if (adv) begin
            dv_xr_ff[j]   <= (xt >= dn) ? xt - dn : xt;
            dv_xq_ff[j]   <= {dv_xq_ff[j-1][MW-2:0], xt >= dn};
            dv_yr_ff[j]   <= (yt >= dn) ? yt - dn : yt;
            dv_yq_ff[j]   <= {dv_yq_ff[j-1][MW-2:0], yt >= dn};
            dv_den_ff[j]  <= dv_den_ff[j-1];
            dv_xs_ff[j]   <= dv_xs_ff[j-1];
            dv_ys_ff[j]   <= dv_ys_ff[j-1];
            dv_neg_ff[j]  <= dv_neg_ff[j-1];
            dv_aneg_ff[j] <= dv_aneg_ff[j-1];
            dv_nq_ff[j]   <= dv_nq_ff[j-1];
         end
      end
   end

   // ---------------- output register ----------------
   function automatic qrs_pkg::root_type sat_root(input logic neg, input logic [MW-1:0] mag);
      logic [XW-1:0] wide;
      wide = XW'(mag);
      if (neg) begin
         sat_root = (wide > XW'(65536)) ? qrs_pkg::ROOT_MIN
                                        : qrs_pkg::ROOT_W'(-wide);
      end else begin
         sat_root = (wide > XW'(65535)) ? qrs_pkg::ROOT_MAX
                                        : qrs_pkg::ROOT_W'(wide);
      end
   endfunction

   logic              rsp_valid_ff, rsp_nq_ff;
   qrs_pkg::root_type r1r_ff, r1i_ff, r2r_ff, r2i_ff;
   qrs_pkg::root_type r1r_in, r1i_in, r2r_in, r2i_in;
   qrs_pkg::root_type qx_s, qy_s;

   always_comb begin
      qx_s = sat_root(dv_xs_ff[MW], dv_xq_ff[MW]);
      qy_s = sat_root(dv_ys_ff[MW], dv_yq_ff[MW]);
      if (dv_nq_ff[MW]) begin
         r1r_in = '0;
         r2r_in = '0;
         r1i_in = '0;
         r2i_in = '0;
      end else if (dv_neg_ff[MW]) begin
         // conjugate pair
         r1r_in = qx_s;
         r2r_in = qx_s;
         r1i_in = sat_root(dv_aneg_ff[MW], dv_yq_ff[MW]);
         r2i_in = sat_root(!dv_aneg_ff[MW], dv_yq_ff[MW]);
      end else begin
         r1r_in = qx_s;
         r2r_in = qy_s;
         r1i_in = '0;
         r2i_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_v_ff[MW];
      end
      if (adv) begin
         r1r_ff    <= r1r_in;
         r1i_ff    <= r1i_in;
         r2r_ff    <= r2r_in;
         r2i_ff    <= r2i_in;
         rsp_nq_ff <= dv_nq_ff[MW];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_root1_real    = r1r_ff;
   assign rsp_root1_imag    = r1i_ff;
   assign rsp_root2_real    = r2r_ff;
   assign rsp_root2_imag    = r2i_ff;
   assign rsp_not_quadratic = rsp_nq_ff;

endmodule

[rtl/qrs_checker.sv]
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks of the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input qrs_pkg::root_type rsp_root1_real,
   input qrs_pkg::root_type rsp_root1_imag,
   input qrs_pkg::root_type rsp_root2_real,
   input qrs_pkg::root_type rsp_root2_imag,
   input logic              rsp_not_quadratic
);

   // No result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Degenerate input gives all-zero roots
   a_nq_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_not_quadratic |->
         rsp_root1_real == '0 && rsp_root1_imag == '0 &&
         rsp_root2_real == '0 && rsp_root2_imag == '0)
      else $error("nonzero root with a = 0");

   // Complex roots share one real part
   a_conj_real: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root1_imag != '0 |-> rsp_root1_real == rsp_root2_real)
      else $error("conjugate pair with differing real parts");

   // An empty output slot never blocks the input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked while output empty");

   // Stalled result stays valid; its real parts and first imaginary part hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_root1_real) &&
         $stable(rsp_root2_real) && $stable(rsp_root1_imag))
      else $error("stalled result changed");

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (.*);
